[sv/assert_macros.svh]
// Assertion macros shared by the string escape decoder modules.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset
`define SEDU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Invariant checked at every rising edge outside reset
`define SEDU_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);
`else
`define SEDU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define SEDU_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`endif
`endif

[sv/sedu_pkg.sv]
// Package for the string escape decoder: types, character codes, helpers.
// No dependencies; used by every module of the block.
package sedu_pkg;

   // queue and burst sizing
   localparam int unsigned MaxBytes = 6;
   localparam int unsigned QDepth   = 4;
   localparam int unsigned QAddrW   = $clog2(QDepth);
   localparam int unsigned QCntW    = $clog2(QDepth + 1);

   typedef logic [7:0] byte_type;

   // escape parser phases
   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_ESC    = 3'd1,
      PH_U0     = 3'd2,
      PH_U1     = 3'd3,
      PH_U2     = 3'd4,
      PH_U3     = 3'd5
   } phase_type;

   // one decoded burst: up to six bytes, first byte at index 0
   typedef struct packed {
      byte_type [MaxBytes-1:0] bytes;
      logic [2:0]              count;
      logic                    last;
   } entry_type;

   // character codes
   localparam byte_type CH_BSLASH = 8'h5C;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_N      = 8'h6E;
   localparam byte_type CH_R      = 8'h72;
   localparam byte_type CH_T      = 8'h74;
   localparam byte_type CH_U      = 8'h75;
   localparam byte_type CH_LF     = 8'h0A;
   localparam byte_type CH_CR     = 8'h0D;
   localparam byte_type CH_TAB    = 8'h09;
   localparam byte_type CH_ZERO   = 8'h30;
   localparam byte_type CH_NINE   = 8'h39;
   localparam byte_type CH_LA     = 8'h61;
   localparam byte_type CH_LF_HEX = 8'h66;
   localparam byte_type CH_UA     = 8'h41;
   localparam byte_type CH_UF_HEX = 8'h46;

   // UTF-8 encoding constants
   localparam logic [15:0] Utf8OneLimit = 16'h0080;
   localparam logic [15:0] Utf8TwoLimit = 16'h0800;
   localparam byte_type    UTF8_CONT    = 8'h80;
   localparam byte_type    UTF8_LEAD2   = 8'hC0;
   localparam byte_type    UTF8_LEAD3   = 8'hE0;
   localparam logic [15:0] UTF8_MASK    = 16'h003F;

   function automatic logic is_upper_hex(byte_type c);
      return (c >= CH_UA) && (c <= CH_UF_HEX);
   endfunction

   function automatic logic is_hex(byte_type c);
      return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
             ((c >= CH_LA) && (c <= CH_LF_HEX)) || is_upper_hex(c);
   endfunction

   // nibble value of a hex digit; don't care for other bytes
   function automatic logic [3:0] hex_nibble(byte_type c);
      byte_type v;
      v = c - CH_ZERO;
      if ((c >= CH_LA) && (c <= CH_LF_HEX)) v = c - CH_LA + 8'd10;
      else if (is_upper_hex(c)) v = c - CH_UA + 8'd10;
      return v[3:0];
   endfunction

   // hex digit character for a nibble, case as recorded
   function automatic byte_type digit_char(logic [3:0] d, logic upper);
      byte_type ch;
      if (d < 4'd10) ch = CH_ZERO + {4'd0, d};
      else if (upper) ch = CH_UA + {4'd0, d} - 8'd10;
      else ch = CH_LA + {4'd0, d} - 8'd10;
      return ch;
   endfunction

endpackage

[sv/sedu_front.sv]
// Front end: accepts string bytes, tracks escape state, builds output bursts.
// Depends on sedu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sedu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_content_byte,
   input  logic                req_last_of_string,
   output logic                req_stall,
   input  logic                q_full,
   output logic                push,
   output sedu_pkg::entry_type push_entry
);
   import sedu_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [2:0][3:0]  hex_ff, hex_in;
   logic [2:0]       held_ff, held_in;

   byte_type         c;
   logic             last, accept, digit_ok, upper, plain_bslash;
   logic [3:0]       nib;
   logic [1:0]       cnt;
   logic [15:0]      code;
   logic [1:0]       sh;
   entry_type        e;

   assign c            = req_content_byte;
   assign last         = req_last_of_string;
   assign req_stall    = q_full;
   assign accept       = req_valid && !q_full;
   assign digit_ok     = is_hex(c);
   assign upper        = is_upper_hex(c);
   assign nib          = hex_nibble(c);
   assign plain_bslash = (c == CH_BSLASH) && !last;
   assign cnt          = 2'(phase_ff - PH_U0);
   assign code         = {hex_ff[2], hex_ff[1], hex_ff[0], nib};

   // next state
   always_comb begin
      phase_in = phase_ff;
      hex_in   = hex_ff;
      held_in  = held_ff;
      case (phase_ff)
         PH_ESC: begin
            phase_in = PH_NORMAL;
            if (c == CH_U && !last) begin
               phase_in = PH_U0;
               hex_in   = '0;
               held_in  = '0;
            end
         end
         PH_U0, PH_U1, PH_U2, PH_U3: begin
            if (digit_ok && cnt == 2'd3) begin
               phase_in = PH_NORMAL;
            end else if (digit_ok && !last) begin
               hex_in       = {hex_ff[1], hex_ff[0], nib};
               held_in[cnt] = upper;
               phase_in     = phase_type'(phase_ff + 3'd1);
            end else begin
               phase_in = plain_bslash ? PH_ESC : PH_NORMAL;
            end
         end
         default: begin
            phase_in = plain_bslash ? PH_ESC : PH_NORMAL;
         end
      endcase
      if (last) phase_in = PH_NORMAL;
   end

   // burst contents
   always_comb begin
      e       = '0;
      e.last  = last;
      sh      = '0;
      case (phase_ff)
         PH_ESC: begin
            e.count = 3'd1;
            case (c)
               CH_QUOTE:  e.bytes[0] = CH_QUOTE;
               CH_BSLASH: e.bytes[0] = CH_BSLASH;
               CH_N:      e.bytes[0] = CH_LF;
               CH_R:      e.bytes[0] = CH_CR;
               CH_T:      e.bytes[0] = CH_TAB;
               CH_U: begin
                  e.bytes[0] = CH_BSLASH;
                  e.bytes[1] = CH_U;
                  e.count    = last ? 3'd2 : 3'd0;
               end
               default: begin
                  e.bytes[0] = CH_BSLASH;
                  e.bytes[1] = c;
                  e.count    = 3'd2;
               end
            endcase
         end
         PH_U0, PH_U1, PH_U2, PH_U3: begin
            if (digit_ok && cnt == 2'd3) begin
               // fourth digit: UTF-8 encode
               if (code < Utf8OneLimit) begin
                  e.bytes[0] = code[7:0];
                  e.count    = 3'd1;
               end else if (code < Utf8TwoLimit) begin
                  e.bytes[0] = UTF8_LEAD2 | {3'd0, code[10:6]};
                  e.bytes[1] = UTF8_CONT | 8'(code & UTF8_MASK);
                  e.count    = 3'd2;
               end else begin
                  e.bytes[0] = UTF8_LEAD3 | {4'd0, code[15:12]};
                  e.bytes[1] = UTF8_CONT | {2'd0, code[11:6]};
                  e.bytes[2] = UTF8_CONT | 8'(code & UTF8_MASK);
                  e.count    = 3'd3;
               end
            end else if (digit_ok && !last) begin
               e.count = 3'd0;
            end else begin
               // broken escape: replay it, then treat the byte as plain text
               e.bytes[0] = CH_BSLASH;
               e.bytes[1] = CH_U;
               for (int k = 0; k < 3; k++) begin
                  if (2'(k) < cnt) begin
                     sh = cnt - 2'(k) - 2'd1;
                     e.bytes[2 + k] = digit_char(hex_ff[sh], held_ff[k]);
                  end
               end
               if (plain_bslash) begin
                  e.count = 3'd2 + {1'b0, cnt};
               end else begin
                  e.bytes[3'd2 + {1'b0, cnt}] = c;
                  e.count = 3'd3 + {1'b0, cnt};
               end
            end
         end
         default: begin
            e.bytes[0] = c;
            e.count    = plain_bslash ? 3'd0 : 3'd1;
         end
      endcase
   end

   assign push       = accept && (e.count != 3'd0);
   assign push_entry = e;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hex_ff  <= hex_in;
         held_ff <= held_in;
      end
   end

   `SEDU_ASSERT_IMPLY(a_last_pushes, clock, reset, accept && last, push, "final byte gave no output")
   `SEDU_ASSERT_IMPLY(a_end_normal, clock, reset, accept && last, ##1 (phase_ff == PH_NORMAL), "phase not normal after string end")

endmodule

[sv/sedu_queue.sv]
// Short FIFO of decoded bursts between the front and back ends.
// Depends on sedu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sedu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sedu_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sedu_pkg::entry_type head
);
   import sedu_pkg::*;

   entry_type          mem [QDepth];
   logic [QAddrW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCntW-1:0]   cnt_ff, cnt_in;
   logic               do_pop;

   assign full       = (cnt_ff == QCntW'(QDepth));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem[rd_ff];
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCntW'(push) - QCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_entry;
   end

   `SEDU_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `SEDU_ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= QCntW'(QDepth), "queue count out of range")

endmodule

[sv/sedu_back.sv]
// Back end: sends the bytes of each queued burst, one per transaction.
// Depends on sedu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sedu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sedu_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_last
);
   import sedu_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   byte_type    byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        load, final_byte;

   assign load       = !valid_ff || !rsp_stall;
   assign final_byte = (idx_ff == head.count - 3'd1);
   assign pop        = load && head_valid && final_byte;

   // byte select and output register next values
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            byte_in = head.bytes[idx_ff];
            last_in = head.last && final_byte;
            idx_in  = final_byte ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   `SEDU_ASSERT_IMPLY(a_idx_in_burst, clock, reset, head_valid, idx_ff < head.count, "byte index beyond burst")

endmodule

[sv/string_escape_decoder_utf8_top.sv]
// Top level of the string escape decoder: front end, burst queue, back end.
// Depends on sedu_pkg, sedu_front, sedu_queue and sedu_back.
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  req     | req_valid req_stall req_content_byte          | in
//          | req_last_of_string                           |
//  rsp     | rsp_valid rsp_stall rsp_out_byte rsp_out_last | out
//
// One input byte is taken per cycle while the four-entry burst queue has room.
// The back end sends one output byte per cycle while rsp_stall is low, so an input
// that decodes to k bytes (up to six) is sent as k output transactions; inputs that
// give no output (escape prefixes, gathered hex digits) put no burst in the queue.
// rsp_valid for the first output byte rises at the earliest once its burst has been
// written into the queue and then loaded into the back-end output register.
// Synchronous reset returns the parser to the normal phase and empties the queue.
// A stall on rsp backs up into the queue and then into req_stall.
module string_escape_decoder_utf8_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_content_byte,
   input  logic       req_last_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import sedu_pkg::*;

   logic      q_full, push, pop, head_valid;
   entry_type push_entry, head;

   sedu_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_content_byte   (req_content_byte),
      .req_last_of_string (req_last_of_string),
      .req_stall          (req_stall),
      .q_full             (q_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   sedu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   sedu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for string_escape_decoder_utf8_top: a directed table
// and random strings, outputs checked against an in-bench decoder model or typed-in expectations.
// Depends on sedu_pkg and the RTL of the string escape decoder.
module testbench;
   import sedu_pkg::*;

   localparam int NumRandom    = 324;
   localparam int LimitCycles  = 200000;
   localparam int DrainCycles  = 10;
   localparam int IdlePct      = 33;
   localparam int HoldStart    = 120;
   localparam int HoldCycles   = 80;
   localparam int CalmFirst    = 200;
   localparam int CalmLast     = 290;
   localparam int PauseA       = 26;
   localparam int PauseB       = 320;

   // one input transaction, with an optional typed-in expectation
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [2:0]  n_want;
      logic [47:0] want;      // byte 0 in bits 7:0
   } stim_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_content_byte = 8'h00;
   logic       req_last_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   string_escape_decoder_utf8_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_content_byte   (req_content_byte),
      .req_last_of_string (req_last_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_last       (rsp_out_last)
   );

   // clock and reset
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LimitCycles) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // decoder model state
   phase_type    parse_phase = PH_NORMAL;
   logic [15:0]  gathered    = 16'h0000;
   logic [7:0]   upper_mask  = 8'h00;
   logic [7:0]   burst_q[$];
   out_beat_type pending_bytes[$];
   stim_type     stim_q[$];
   stim_type     directed_tab[0:25];

   int errors         = 0;
   int accepted_items = 0;
   int strings_done   = 0;
   int bytes_checked  = 0;

   function automatic int digit_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF_HEX) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] d, logic upper);
      if (d < 4'd10) return CH_ZERO + {4'd0, d};
      if (upper) return CH_UA + {4'd0, d} - 8'd10;
      return CH_LA + {4'd0, d} - 8'd10;
   endfunction

   // append one byte to the current burst
   function automatic void emit_byte(logic [7:0] b);
      burst_q = {burst_q, b};
   endfunction

   // byte seen in the normal phase
   function automatic void plain_byte(logic [7:0] c, logic last);
      if (c == CH_BSLASH && !last) begin
         parse_phase = PH_ESC;
      end else begin
         emit_byte(c);
         parse_phase = PH_NORMAL;
      end
   endfunction

   // broken \u: give back what was swallowed, digit case kept
   function automatic void replay_escape(int cnt);
      logic [15:0] sh;
      emit_byte(CH_BSLASH);
      emit_byte(CH_U);
      for (int k = 0; k < cnt; k++) begin
         sh = gathered >> (4 * (cnt - 1 - k));
         emit_byte(hex_char(sh[3:0], upper_mask[k]));
      end
   endfunction

   function automatic void put_utf8(logic [15:0] code);
      if (code < 16'h0080) begin
         emit_byte(code[7:0]);
      end else if (code < 16'h0800) begin
         emit_byte(UTF8_LEAD2 | {3'd0, code[10:6]});
         emit_byte(UTF8_CONT | {2'd0, code[5:0]});
      end else begin
         emit_byte(UTF8_LEAD3 | {4'd0, code[15:12]});
         emit_byte(UTF8_CONT | {2'd0, code[11:6]});
         emit_byte(UTF8_CONT | {2'd0, code[5:0]});
      end
   endfunction

   // decode one input byte into burst_q and advance the parser
   function automatic void decode_byte(logic [7:0] c, logic last);
      int h;
      int cnt;
      logic [3:0] nib;
      burst_q.delete();
      case (parse_phase)
         PH_ESC: begin
            parse_phase = PH_NORMAL;
            case (c)
               CH_QUOTE:  emit_byte(CH_QUOTE);
               CH_BSLASH: emit_byte(CH_BSLASH);
               CH_N:      emit_byte(CH_LF);
               CH_R:      emit_byte(CH_CR);
               CH_T:      emit_byte(CH_TAB);
               CH_U: begin
                  if (last) begin
                     emit_byte(CH_BSLASH);
                     emit_byte(CH_U);
                  end else begin
                     parse_phase = PH_U0;
                     gathered = 16'h0000;
                     upper_mask = 8'h00;
                  end
               end
               default: begin
                  emit_byte(CH_BSLASH);
                  emit_byte(c);
               end
            endcase
         end
         PH_U0, PH_U1, PH_U2, PH_U3: begin
            cnt = int'(parse_phase) - int'(PH_U0);
            h = digit_value(c);
            nib = h[3:0];
            if (h >= 0 && cnt == 3) begin
               put_utf8({gathered[11:0], nib});
               parse_phase = PH_NORMAL;
            end else if (h >= 0 && !last) begin
               gathered = {gathered[11:0], nib};
               upper_mask[cnt] = (c >= CH_UA && c <= CH_UF_HEX);
               parse_phase = phase_type'(int'(parse_phase) + 1);
            end else begin
               replay_escape(cnt);
               plain_byte(c, last);
            end
         end
         default: plain_byte(c, last);
      endcase
      if (last) parse_phase = PH_NORMAL;
   endfunction

   // accepted transaction: queue what it must produce
   function automatic void expect_from(stim_type it);
      out_beat_type beat;
      decode_byte(it.data, it.last);
      if (it.typed) begin
         burst_q.delete();
         for (int k = 0; k < int'(it.n_want); k++) emit_byte(it.want[8*k +: 8]);
      end
      for (int k = 0; k < burst_q.size(); k++) begin
         beat.data = burst_q[k];
         beat.last = it.last && (k == burst_q.size() - 1);
         pending_bytes = {pending_bytes, beat};
      end
      accepted_items++;
      if (it.last) strings_done++;
   endfunction

   function automatic void add_item(logic [7:0] c, logic last);
      stim_type it;
      it = '{c, last, 1'b0, 3'd0, 48'h0};
      stim_q = {stim_q, it};
   endfunction

   // random string built from segments, mostly escape sequences
   function automatic void add_random_string();
      logic [7:0]  str_q[$];
      logic [7:0]  b;
      logic [15:0] code;
      int segs;
      int kind;
      int digits;
      segs = $urandom_range(1, 5);
      for (int s = 0; s < segs; s++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_BSLASH) b = CH_LA;
            str_q = {str_q, b};
         end else if (kind < 45) begin
            str_q = {str_q, CH_BSLASH};
            case ($urandom_range(0, 4))
               0: str_q = {str_q, CH_QUOTE};
               1: str_q = {str_q, CH_BSLASH};
               2: str_q = {str_q, CH_N};
               3: str_q = {str_q, CH_R};
               default: str_q = {str_q, CH_T};
            endcase
         end else if (kind < 75) begin
            // well-formed \uXXXX across the UTF-8 length classes
            case ($urandom_range(0, 3))
               0: code = 16'($urandom_range(16'h0000, 16'h007F));
               1: code = 16'($urandom_range(16'h0080, 16'h07FF));
               2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
               default: code = 16'($urandom_range(16'hD800, 16'hDFFF));
            endcase
            str_q = {str_q, CH_BSLASH};
            str_q = {str_q, CH_U};
            for (int k = 3; k >= 0; k--) begin
               b = hex_char(code[4*k +: 4], 1'($urandom_range(0, 1)));
               str_q = {str_q, b};
            end
         end else if (kind < 88) begin
            // broken \u: up to three digits, then a non-hex byte or the end
            digits = $urandom_range(0, 3);
            str_q = {str_q, CH_BSLASH};
            str_q = {str_q, CH_U};
            for (int k = 0; k < digits; k++) begin
               b = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
               str_q = {str_q, b};
            end
            if (s != segs - 1 || $urandom_range(0, 1)) begin
               b = 8'($urandom_range(0, 255));
               while (digit_value(b) >= 0) b = 8'($urandom_range(0, 255));
               str_q = {str_q, b};
            end
         end else if (kind < 95) begin
            // unknown escape
            str_q = {str_q, CH_BSLASH};
            b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE || b == CH_BSLASH || b == CH_N || b == CH_R ||
                   b == CH_T || b == CH_U)
               b = 8'($urandom_range(0, 255));
            str_q = {str_q, b};
         end else begin
            // noise: any byte, backslashes included
            b = $urandom_range(0, 1) ? CH_BSLASH : 8'($urandom_range(0, 255));
            str_q = {str_q, b};
         end
      end
      for (int k = 0; k < str_q.size(); k++) add_item(str_q[k], k == str_q.size() - 1);
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %h want %h at output byte %0d", what, got, want,
               bytes_checked);
      errors++;
   endtask

   // sender: walks the stimulus, then waits for the block to drain
   initial begin : feed
      int  idx;
      bit  took;
      bit  calm;
      directed_tab[0]  = '{8'h00,     1'b0, 1'b1, 3'd1, 48'h00};
      directed_tab[1]  = '{8'hFF,     1'b0, 1'b1, 3'd1, 48'hFF};
      directed_tab[2]  = '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 48'h0};
      directed_tab[3]  = '{CH_QUOTE,  1'b0, 1'b1, 3'd1, {40'h0, CH_QUOTE}};
      directed_tab[4]  = '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 48'h0};
      directed_tab[5]  = '{CH_BSLASH, 1'b0, 1'b1, 3'd1, {40'h0, CH_BSLASH}};
      directed_tab[6]  = '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 48'h0};
      directed_tab[7]  = '{CH_N,      1'b0, 1'b1, 3'd1, {40'h0, CH_LF}};
      directed_tab[8]  = '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 48'h0};
      directed_tab[9]  = '{CH_R,      1'b0, 1'b1, 3'd1, {40'h0, CH_CR}};
      directed_tab[10] = '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 48'h0};
      directed_tab[11] = '{CH_T,      1'b1, 1'b1, 3'd1, {40'h0, CH_TAB}};
      // unknown escape keeps the backslash
      directed_tab[12] = '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 48'h0};
      directed_tab[13] = '{"q",       1'b0, 1'b1, 3'd2, {32'h0, "q", CH_BSLASH}};
      // largest code point, mixed-case digits
      directed_tab[14] = '{CH_BSLASH, 1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[15] = '{CH_U,      1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[16] = '{"F",       1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[17] = '{"f",       1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[18] = '{"F",       1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[19] = '{"f",       1'b0, 1'b0, 3'd0, 48'h0};
      // broken escape whose breaking byte starts a new one, then cut off
      directed_tab[20] = '{CH_BSLASH, 1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[21] = '{CH_U,      1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[22] = '{"7",       1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[23] = '{CH_BSLASH, 1'b0, 1'b0, 3'd0, 48'h0};
      directed_tab[24] = '{CH_U,      1'b1, 1'b1, 3'd2, {32'h0, CH_U, CH_BSLASH}};
      // backslash as the final byte
      directed_tab[25] = '{CH_BSLASH, 1'b1, 1'b1, 3'd1, {40'h0, CH_BSLASH}};
      for (int r = 0; r < 26; r++) stim_q = {stim_q, directed_tab[r]};
      while (stim_q.size() < 26 + NumRandom) add_random_string();

      while (reset) @(posedge clock);
      idx = 0;
      while (idx < stim_q.size()) begin
         @(posedge clock);
         took = req_valid && !req_stall;
         if (took) begin
            expect_from(stim_q[idx]);
            idx++;
         end
         calm = (idx >= CalmFirst) && (idx < CalmLast);
         if (req_valid && !took) begin
            // stalled: payload holds
         end else if (idx >= stim_q.size()) begin
            req_valid <= 1'b0;
         end else if ((idx == PauseA || idx == PauseB) && pending_bytes.size() != 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < IdlePct) begin
            req_valid <= 1'b0;
         end else begin
            req_valid          <= 1'b1;
            req_content_byte   <= stim_q[idx].data;
            req_last_of_string <= stim_q[idx].last;
         end
      end

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d strings from %0d input bytes; %0d output bytes compared, %0d errors",
               strings_done, accepted_items, bytes_checked, errors);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // receiver: checks each output transaction, drives the stall
   initial begin : drain
      out_beat_type exp_beat;
      int  hold_left;
      bit  hold_done;
      bit  calm;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch("unexpected byte", rsp_out_byte, 8'h00);
            end else begin
               exp_beat = pending_bytes.pop_front();
               if (rsp_out_byte !== exp_beat.data)
                  report_mismatch("out_byte", rsp_out_byte, exp_beat.data);
               if (rsp_out_last !== exp_beat.last)
                  report_mismatch("out_last", {7'd0, rsp_out_last}, {7'd0, exp_beat.last});
            end
            bytes_checked++;
         end
         calm = (accepted_items >= CalmFirst) && (accepted_items < CalmLast);
         if (hold_left > 0) begin
            // long back-pressure so the burst queue fills
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && accepted_items >= HoldStart) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IdlePct);
         end
      end
   end

endmodule

[files.f]
+incdir+sv
sv/sedu_pkg.sv
sv/sedu_front.sv
sv/sedu_queue.sv
sv/sedu_back.sv
sv/string_escape_decoder_utf8_top.sv
tb/sv/testbench.sv
